// File: rtl/huf_pkg.sv
// ----------------------------------------------------------------------------
// huf_pkg - shared codes for the Huffman tree decoder
// Function codes of the input item, result status codes and byte constants.
// ----------------------------------------------------------------------------
`default_nettype none

package huf_pkg;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_DECODE = 1'b1;

	localparam logic [1:0] ST_SYMBOL   = 2'd0;
	localparam logic [1:0] ST_INSERTED = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_INVALID  = 2'd3;

	localparam int BYTE_BITS = 8;
	localparam int BYTE_MSB  = 7;
	localparam int BCNT_W    = 4;

	typedef logic [1:0] status_t;

endpackage

`default_nettype wire

// File: rtl/huf_ram.sv
// ----------------------------------------------------------------------------
// huf_ram - generic simple dual-port RAM
// One write port, one read port with registered read data held when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module huf_ram #(
	parameter int WIDTH = 29,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/huffman_tree_decoder.sv
// ----------------------------------------------------------------------------
// huffman_tree_decoder - Huffman decode tree builder and bit-serial walker
// Inserts codewords into a node table and decodes coded bytes bit by bit.
// ----------------------------------------------------------------------------
// Decode: busy holds while the walk steps through the bits, emits at each leaf
//   or dead end and closes; the final result strobes in the cycle busy drops.
// Insert: busy for alignment shifts, the table walk along the code bits and the
//   leaf write, ending early on table full; zero length answers without busy.
// Results cannot be stalled. After reset the node table is cleared with busy
//   high; walk position resets to the root, free counter to 1.
`default_nettype none

module huffman_tree_decoder
	import huf_pkg::*;
#(
	parameter int MAX_CODE_LEN = 32,
	parameter int NODE_COUNT   = 512
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        func,
	input  wire logic [31:0] code_bits,
	input  wire logic [5:0]  code_length,
	input  wire logic [7:0]  entry_symbol,
	input  wire logic [7:0]  data_byte,
	output logic             strobe,
	output logic      [7:0]  symbol,
	output logic      [1:0]  status,
	output logic             last
);

	localparam int IW   = $clog2(NODE_COUNT);
	localparam int NFW  = $clog2(NODE_COUNT + 1);
	localparam int CNTW = $clog2(MAX_CODE_LEN + 1);
	localparam int LW   = (CNTW > 6) ? CNTW : 6;
	localparam int CW   = (MAX_CODE_LEN > 32) ? MAX_CODE_LEN : 32;

	typedef struct packed {
		logic                   leaf;
		logic [7:0]             sym;
		logic [1:0]             has;
		logic [1:0][IW-1:0]     child;
	} node_t;

	localparam int NODE_W = $bits(node_t);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_ALIGN = 3'd2;
	localparam logic [2:0] S_INS   = 3'd3;
	localparam logic [2:0] S_DEC   = 3'd4;

	logic [2:0]              state_q, state_d;
	logic [IW-1:0]           clr_q;
	logic [NFW-1:0]          free_q;
	logic [IW-1:0]           walk_q;
	logic [IW-1:0]           cur_q, cur_d;
	logic                    chk_q, chk_d;
	logic [MAX_CODE_LEN-1:0] code_q;
	logic [CNTW-1:0]         cnt_q;
	logic [CNTW-1:0]         len_q;
	logic [7:0]              isym_q;
	logic [BYTE_BITS-1:0]    byte_q;
	logic [BCNT_W-1:0]       bcnt_q;

	logic                    pend_v_q;
	logic [7:0]              pend_sym_q;
	status_t                 pend_st_q;

	node_t                   rnode, wnode;
	logic [NODE_W-1:0]       rdata;
	logic                    re, we;
	logic [IW-1:0]           raddr, waddr;

	logic                    emit, flush;
	logic [7:0]              e_sym;
	status_t                 e_st;

	logic                    accept, full, cbit, dbit;
	logic [LW-1:0]           len_ext;
	logic [CNTW-1:0]         len_sat;
	logic [CW-1:0]           code_ext;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign full     = (free_q == NFW'(NODE_COUNT));
	assign rnode    = node_t'(rdata);
	assign cbit     = code_q[MAX_CODE_LEN-1];
	assign dbit     = byte_q[BYTE_MSB];
	assign len_ext  = LW'(code_length);
	assign len_sat  = (len_ext > LW'(MAX_CODE_LEN)) ? CNTW'(MAX_CODE_LEN) : CNTW'(len_ext);
	assign code_ext = CW'(code_bits);

	huf_ram #(
		.WIDTH(NODE_W),
		.DEPTH(NODE_COUNT)
	) u_node_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wnode),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		state_d = state_q;
		cur_d   = cur_q;
		chk_d   = chk_q;
		re      = 1'b0;
		raddr   = '0;
		we      = 1'b0;
		waddr   = cur_q;
		wnode   = rnode;
		emit    = 1'b0;
		flush   = 1'b0;
		e_sym   = '0;
		e_st    = ST_SYMBOL;
		unique case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wnode = '0;
				if (clr_q == IW'(NODE_COUNT - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					re = 1'b1;
					chk_d = 1'b0;
					if (func == FUNC_DECODE) begin
						raddr   = walk_q;
						cur_d   = walk_q;
						state_d = S_DEC;
					end else if (code_length == '0) begin
						emit  = 1'b1;
						flush = 1'b1;
						e_st  = ST_INVALID;
					end else begin
						raddr   = '0;
						cur_d   = '0;
						state_d = S_ALIGN;
					end
				end
			end
			S_ALIGN: begin
				// read data of the root stays held until the walk begins
				if (cnt_q == len_q) begin
					state_d = S_INS;
				end
			end
			S_INS: begin
				if (cnt_q == '0) begin
					we         = 1'b1;
					wnode.leaf = 1'b1;
					wnode.sym  = isym_q;
					emit       = 1'b1;
					flush      = 1'b1;
					e_st       = ST_INSERTED;
					state_d    = S_IDLE;
				end else if (rnode.has[cbit]) begin
					re    = 1'b1;
					raddr = rnode.child[cbit];
					cur_d = rnode.child[cbit];
				end else if (full) begin
					emit    = 1'b1;
					flush   = 1'b1;
					e_st    = ST_FULL;
					state_d = S_IDLE;
				end else begin
					// new child: parent gets the link, the child is zero from the clear pass
					we               = 1'b1;
					wnode.has[cbit]  = 1'b1;
					wnode.child[cbit] = free_q[IW-1:0];
					re               = 1'b1;
					raddr            = free_q[IW-1:0];
					cur_d            = free_q[IW-1:0];
				end
			end
			S_DEC: begin
				if (chk_q && rnode.leaf) begin
					emit  = 1'b1;
					e_sym = rnode.sym;
					e_st  = ST_SYMBOL;
					re    = 1'b1;
					raddr = '0;
					cur_d = '0;
					chk_d = 1'b0;
				end else if (bcnt_q == '0) begin
					flush   = 1'b1;
					state_d = S_IDLE;
				end else if (rnode.has[dbit]) begin
					re    = 1'b1;
					raddr = rnode.child[dbit];
					cur_d = rnode.child[dbit];
					chk_d = 1'b1;
				end else begin
					emit  = 1'b1;
					e_st  = ST_INVALID;
					re    = 1'b1;
					raddr = '0;
					cur_d = '0;
					chk_d = 1'b0;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			free_q   <= NFW'(1);
			walk_q   <= '0;
			cur_q    <= '0;
			chk_q    <= 1'b0;
			pend_v_q <= 1'b0;
			strobe   <= 1'b0;
		end else begin
			state_q <= state_d;
			cur_q   <= cur_d;
			chk_q   <= chk_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + IW'(1);
			end
			if (state_q == S_INS && cnt_q != '0 && !rnode.has[cbit] && !full) begin
				free_q <= free_q + NFW'(1);
			end
			if (state_q == S_DEC && flush) begin
				walk_q <= cur_q;
			end
			// one result is held back so the final one of an item can carry last
			strobe <= (emit && pend_v_q) || (flush && (pend_v_q || emit));
			if (flush) begin
				pend_v_q <= 1'b0;
			end else if (emit) begin
				pend_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pend_sym_q <= e_sym;
			pend_st_q  <= e_st;
		end
		if (pend_v_q && (emit || flush)) begin
			symbol <= pend_sym_q;
			status <= pend_st_q;
			last   <= flush;
		end else begin
			symbol <= e_sym;
			status <= e_st;
			last   <= 1'b1;
		end
		if (accept) begin
			code_q <= code_ext[MAX_CODE_LEN-1:0];
			cnt_q  <= CNTW'(MAX_CODE_LEN);
			len_q  <= len_sat;
			isym_q <= entry_symbol;
			byte_q <= data_byte;
			bcnt_q <= BCNT_W'(BYTE_BITS);
		end else if (state_q == S_ALIGN && cnt_q != len_q) begin
			code_q <= code_q << 1;
			cnt_q  <= cnt_q - CNTW'(1);
		end else if (state_q == S_INS && cnt_q != '0 && (rnode.has[cbit] || !full)) begin
			code_q <= code_q << 1;
			cnt_q  <= cnt_q - CNTW'(1);
		end else if (state_q == S_DEC && !(chk_q && rnode.leaf) && bcnt_q != '0) begin
			byte_q <= byte_q << 1;
			bcnt_q <= bcnt_q - BCNT_W'(1);
		end
	end

	// a held-back result must never be dropped by an item end that also emits
	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(emit && flush && pend_v_q))
		else $error("result lost at item end");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_v_q)
		else $error("pending result left over while idle");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(free_q <= NFW'(NODE_COUNT)) && (free_q != '0))
		else $error("free node counter out of range");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |=> !strobe)
		else $error("result during clear pass");

	a_decode_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == FUNC_DECODE) |=> busy)
		else $error("decode transfer did not start a walk");

endmodule

`default_nettype wire

// File: tb/huffman_tree_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_decoder_test - self-checking bench for the Huffman tree decoder
// A directed table of inserts and decodes, then random codebook growth with
// decode bytes mostly cut from paths of the current tree, then a fill to table
// full, more random items. Typed rows or a local tree model check each result.
// ----------------------------------------------------------------------------

module huffman_tree_decoder_test
	import huf_pkg::*;
();

	localparam int NODES        = 512;
	localparam int CODE_MAX     = 32;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [7:0] symbol;
		status_t    status;
		logic       last;
	} result_t;

	// n_typed != 0: that many results of typ_st/typ_sym are expected, last on the final
	typedef struct packed {
		logic        func;
		logic [31:0] bits;
		logic [5:0]  len;
		logic [7:0]  sym;
		logic [7:0]  dbyte;
		logic [3:0]  n_typed;
		status_t     typ_st;
		logic [7:0]  typ_sym;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        func;
	logic [31:0] code_bits;
	logic [5:0]  code_length;
	logic [7:0]  entry_symbol;
	logic [7:0]  data_byte;
	logic        strobe;
	logic [7:0]  symbol;
	logic [1:0]  status;
	logic        last;

	// model of the decode tree
	logic       tree_leaf  [NODES];
	logic [7:0] tree_sym   [NODES];
	logic       tree_has   [NODES][2];
	logic [8:0] tree_child [NODES][2];
	logic [9:0] free_node;
	logic [8:0] walk_node;

	result_t    step_results[$];
	result_t    expected_results[$];
	bit         code_stream[$];
	logic [8:0] stream_end;

	int burst_left  = 1;
	int errors      = 0;
	int idle_cycles = 0;

	huffman_tree_decoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.code_bits    (code_bits),
		.code_length  (code_length),
		.entry_symbol (entry_symbol),
		.data_byte    (data_byte),
		.strobe       (strobe),
		.symbol       (symbol),
		.status       (status),
		.last         (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic clear_node(input logic [8:0] n);
		tree_leaf[n]     = 1'b0;
		tree_sym[n]      = 8'h00;
		tree_has[n][0]   = 1'b0;
		tree_has[n][1]   = 1'b0;
		tree_child[n][0] = '0;
		tree_child[n][1] = '0;
	endtask

	// results of one item land in step_results
	task automatic tree_step(input logic f, input logic [31:0] bits, input logic [5:0] len,
			input logic [7:0] sym, input logic [7:0] dbyte);
		int         n_len;
		logic [8:0] pos;
		logic [8:0] fresh;
		logic       b;
		status_t    st;
		bit         stopped;
		result_t    tail;
		step_results.delete();
		if (f == FUNC_INSERT) begin
			st      = ST_INSERTED;
			stopped = 1'b0;
			pos     = '0;
			if (len == 0) begin
				st = ST_INVALID;
			end else begin
				n_len = (len > CODE_MAX) ? CODE_MAX : int'(len);
				for (int i = n_len; i > 0 && !stopped; i--) begin
					b = bits[i-1];
					if (!tree_has[pos][b]) begin
						if (free_node >= NODES) begin
							st      = ST_FULL;
							stopped = 1'b1;
						end else begin
							fresh = free_node[8:0];
							free_node++;
							clear_node(fresh);
							tree_has[pos][b]   = 1'b1;
							tree_child[pos][b] = fresh;
						end
					end
					if (!stopped)
						pos = tree_child[pos][b];
				end
				if (!stopped) begin
					tree_leaf[pos] = 1'b1;
					tree_sym[pos]  = sym;
				end
			end
			step_results.push_back('{symbol: 8'h00, status: st, last: 1'b0});
		end else begin
			for (int i = BYTE_MSB; i >= 0; i--) begin
				b = dbyte[i];
				if (!tree_has[walk_node][b]) begin
					step_results.push_back('{symbol: 8'h00, status: ST_INVALID, last: 1'b0});
					walk_node = '0;
				end else begin
					walk_node = tree_child[walk_node][b];
					if (tree_leaf[walk_node]) begin
						step_results.push_back('{symbol: tree_sym[walk_node],
							status: ST_SYMBOL, last: 1'b0});
						walk_node = '0;
					end
				end
			end
		end
		if (step_results.size() > 0) begin
			tail      = step_results.pop_back();
			tail.last = 1'b1;
			step_results.push_back(tail);
		end
	endtask

	// Next coded byte taken from random root-to-leaf paths of the current tree,
	// continuing from wherever the walk will stand when it is decoded.
	task automatic stream_byte(output logic [7:0] byte_out);
		logic [8:0] n;
		logic       b;
		bit         done;
		if (code_stream.size() == 0)
			stream_end = walk_node;
		while (code_stream.size() < BYTE_BITS) begin
			n    = stream_end;
			done = 1'b0;
			while (!done) begin
				if (tree_has[n][0] && tree_has[n][1]) begin
					b = 1'($urandom_range(1));
				end else if (tree_has[n][0]) begin
					b = 1'b0;
				end else if (tree_has[n][1]) begin
					b = 1'b1;
				end else begin
					// bare root, or a node stranded by a full table: bit is invalid
					code_stream.push_back(1'($urandom_range(1)));
					n    = '0;
					done = 1'b1;
				end
				if (!done) begin
					code_stream.push_back(b);
					n    = tree_child[n][b];
					done = tree_leaf[n];
					if (done)
						n = '0;
				end
			end
			stream_end = n;
		end
		for (int i = BYTE_MSB; i >= 0; i--)
			byte_out[i] = code_stream.pop_front();
	endtask

	task automatic pace();
		burst_left--;
		if (burst_left <= 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
		end
	endtask

	// present one item, wait for its transfer, then queue what it should produce
	task automatic send_item(input stim_row_t row, output status_t first_st);
		start        <= 1'b1;
		func         <= row.func;
		code_bits    <= row.bits;
		code_length  <= row.len;
		entry_symbol <= row.sym;
		data_byte    <= row.dbyte;
		do @(posedge clk); while (busy !== 1'b0);
		tree_step(row.func, row.bits, row.len, row.sym, row.dbyte);
		first_st = (step_results.size() > 0) ? step_results[0].status : ST_SYMBOL;
		if (row.n_typed != 0) begin
			for (int k = 0; k < row.n_typed; k++)
				expected_results.push_back('{symbol: row.typ_sym, status: row.typ_st,
					last: (k == row.n_typed - 1)});
		end else begin
			foreach (step_results[k])
				expected_results.push_back(step_results[k]);
		end
		@(negedge clk);
		pace();
	endtask

	task automatic random_item(input int insert_pct, output status_t first_st);
		stim_row_t  row;
		logic [31:0] path;
		int         depth;
		int         target;
		int         pick;
		logic [8:0] n;
		logic       b;
		row       = '0;
		row.bits  = $urandom;
		row.sym   = 8'($urandom);
		row.dbyte = 8'($urandom);
		if ($urandom_range(99) < insert_pct) begin
			row.func = FUNC_INSERT;
			code_stream.delete();
			pick = $urandom_range(99);
			if (pick < 5) begin
				row.len = 6'($urandom_range(63));
			end else if (pick < 20) begin
				// follow an existing path: overwrites an interior node or a leaf
				path   = '0;
				depth  = 0;
				n      = '0;
				target = $urandom_range(1, 6);
				while (depth < target && (tree_has[n][0] || tree_has[n][1])) begin
					if (tree_has[n][0] && tree_has[n][1])
						b = 1'($urandom_range(1));
					else
						b = tree_has[n][1];
					path = {path[30:0], b};
					n    = tree_child[n][b];
					depth++;
				end
				if (depth == 0)
					depth = 1;
				row.len  = 6'(depth);
				row.bits = (row.bits << depth) | path;
			end else begin
				row.len = (pick < 95) ? 6'($urandom_range(3, 10)) : 6'($urandom_range(11, 32));
				// keep most new codes in the one subtree left open by the directed part
				if ($urandom_range(99) < 60) begin
					row.bits[row.len-1] = 1'b1;
					row.bits[row.len-2] = 1'b0;
				end
			end
		end else begin
			row.func = FUNC_DECODE;
			if ($urandom_range(99) < 20)
				code_stream.delete();
			else
				stream_byte(row.dbyte);
		end
		send_item(row, first_st);
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && strobe) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: symbol %02h status %0d last %0b",
					symbol, status, last);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (symbol !== want.symbol) begin
					$error("symbol: expected %02h, got %02h", want.symbol, symbol);
					errors++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles with neither an input transfer nor a result
	always @(posedge clk) begin
		if (!arst_n || strobe || (start && busy === 1'b0))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		stim_row_t dir_rows [21];
		stim_row_t fill_row;
		status_t   st;
		int        fill_tries;
		arst_n       = 1'b0;
		start        = 1'b0;
		func         = FUNC_INSERT;
		code_bits    = '0;
		code_length  = '0;
		entry_symbol = '0;
		data_byte    = '0;
		for (int i = 0; i < NODES; i++)
			clear_node(9'(i));
		free_node = 10'd1;
		walk_node = '0;

		// func, bits, len, sym, byte, typed count, typed status, typed symbol
		dir_rows = '{
			// empty tree: every bit is an invalid path
			'{FUNC_DECODE, 32'h0000_0000, 6'd0,  8'h00, 8'h00, 4'd8, ST_INVALID,  8'h00},
			'{FUNC_DECODE, 32'h0000_0000, 6'd0,  8'h00, 8'hFF, 4'd8, ST_INVALID,  8'h00},
			// zero length is refused
			'{FUNC_INSERT, 32'hFFFF_FFFF, 6'd0,  8'h55, 8'h00, 4'd1, ST_INVALID,  8'h00},
			// code "0", upper bits are junk
			'{FUNC_INSERT, 32'hFFFF_FFFE, 6'd1,  8'h41, 8'h00, 4'd1, ST_INSERTED, 8'h00},
			// code "110"
			'{FUNC_INSERT, 32'h0000_0006, 6'd3,  8'h42, 8'h00, 4'd1, ST_INSERTED, 8'h00},
			'{FUNC_DECODE, 32'h0000_0000, 6'd0,  8'h00, 8'h00, 4'd8, ST_SYMBOL,   8'h41},
			'{FUNC_DECODE, 32'h0000_0000, 6'd0,  8'h00, 8'hC0, 4'd0, ST_SYMBOL,   8'h00},
			// missing child "10" mid-byte
			'{FUNC_DECODE, 32'h0000_0000, 6'd0,  8'h00, 8'h80, 4'd0, ST_SYMBOL,   8'h00},
			// byte ends inside a code, the walk carries over
			'{FUNC_DECODE, 32'h0000_0000, 6'd0,  8'h00, 8'h01, 4'd0, ST_SYMBOL,   8'h00},
			'{FUNC_DECODE, 32'h0000_0000, 6'd0,  8'h00, 8'h80, 4'd0, ST_SYMBOL,   8'h00},
			'{FUNC_DECODE, 32'h0000_0000, 6'd0,  8'h00, 8'h03, 4'd0, ST_SYMBOL,   8'h00},
			'{FUNC_DECODE, 32'h0000_0000, 6'd0,  8'h00, 8'h7F, 4'd0, ST_SYMBOL,   8'h00},
			'{FUNC_DECODE, 32'h0000_0000, 6'd0,  8'h00, 8'hFF, 4'd0, ST_SYMBOL,   8'h00},
			// full-length codes; lengths above the maximum saturate
			'{FUNC_INSERT, 32'hFFFF_FFFF, 6'd32, 8'hFF, 8'h00, 4'd1, ST_INSERTED, 8'h00},
			'{FUNC_INSERT, 32'hFFFF_FFFE, 6'd63, 8'h00, 8'h00, 4'd1, ST_INSERTED, 8'h00},
			'{FUNC_INSERT, 32'h0000_0000, 6'd33, 8'h7E, 8'h00, 4'd1, ST_INSERTED, 8'h00},
			// "11" is interior: becomes a leaf, children kept
			'{FUNC_INSERT, 32'h0000_0003, 6'd2,  8'h80, 8'h00, 4'd1, ST_INSERTED, 8'h00},
			'{FUNC_DECODE, 32'h0000_0000, 6'd0,  8'h00, 8'hE5, 4'd0, ST_SYMBOL,   8'h00},
			// leaf "0" takes a new symbol
			'{FUNC_INSERT, 32'h0000_0000, 6'd1,  8'h81, 8'h00, 4'd1, ST_INSERTED, 8'h00},
			'{FUNC_DECODE, 32'h0000_0000, 6'd0,  8'h00, 8'h5A, 4'd0, ST_SYMBOL,   8'h00},
			'{FUNC_DECODE, 32'h0000_0000, 6'd0,  8'h00, 8'h00, 4'd8, ST_SYMBOL,   8'h81}
		};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[r])
			send_item(dir_rows[r], st);

		repeat (50) random_item(70, st);
		repeat (180) random_item(30, st);

		// long random codes until the free counter runs out, at most 40 tries
		fill_tries = 0;
		st         = ST_INSERTED;
		while (st != ST_FULL && fill_tries < 40) begin
			fill_row      = '0;
			fill_row.func = FUNC_INSERT;
			fill_row.bits = $urandom;
			fill_row.len  = 6'(CODE_MAX);
			fill_row.sym  = 8'($urandom);
			code_stream.delete();
			send_item(fill_row, st);
			fill_tries++;
		end

		repeat (25) random_item(40, st);
		start <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
